// ----- rtl/aes_pkg.sv -----
package aes_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW       = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NONCE         = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_COUNTER_START = 2'd3;
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned NumRegs  = 4;

  typedef struct packed {
    logic start;
    logic key_add;
    logic last;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] round;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

// ----- rtl/aes_ctrl.sv -----
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  aes_pkg::dp_stat_t stat,
  output aes_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       hold;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;
    hold          = (stat.round == 4'd10) && out_valid_r && out_stall;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!hold) begin
          cmd.advance = 1'b1;
          cmd.key_add = (stat.round == 4'd0);
          cmd.last    = (stat.round == 4'd10);
          if (stat.round == 4'd10) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && stat.round == 4'd10 && !hold) |=>
      state_r == ST_IDLE && out_valid)
    else $error("run did not end in output");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> in_stall)
    else $error("input taken while busy");
  a_start_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> stat.round == 4'd0)
    else $error("round not cleared at start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ----- rtl/aes_dp.sv -----
module aes_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [63:0]                  cfg_wdata,
  input  logic [63:0]                  in_text_high,
  input  logic [63:0]                  in_text_low,
  input  aes_pkg::dp_cmd_t             cmd,
  output aes_pkg::dp_stat_t            stat,
  output logic [63:0]                  out_result_high,
  output logic [63:0]                  out_result_low
);

  logic [63:0]  key_hi_r, key_lo_r, nonce_r, ctr_r;
  logic [127:0] st_r, txt_r, rk_r, res_r;
  logic [127:0] st_nxt, rk_nxt, sr, mc;
  logic [7:0]   rc_r;
  logic [3:0]   round_r;
  logic [31:0]  t;

  assign stat.round = round_r;

  always_comb begin
    t      = aes_pkg::sub_word({rk_r[23:0], rk_r[31:24]}) ^ {rc_r, 24'h0};
    rk_nxt[127:96] = rk_r[127:96] ^ t;
    rk_nxt[95:64]  = rk_r[95:64]  ^ rk_nxt[127:96];
    rk_nxt[63:32]  = rk_r[63:32]  ^ rk_nxt[95:64];
    rk_nxt[31:0]   = rk_r[31:0]   ^ rk_nxt[63:32];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = aes_pkg::sbox(st_r[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127-32*c -: 8];
      a1 = sr[119-32*c -: 8];
      a2 = sr[111-32*c -: 8];
      a3 = sr[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8] = a0 ^ al ^ aes_pkg::xt(a0 ^ a1);
      mc[119-32*c -: 8] = a1 ^ al ^ aes_pkg::xt(a1 ^ a2);
      mc[111-32*c -: 8] = a2 ^ al ^ aes_pkg::xt(a2 ^ a3);
      mc[103-32*c -: 8] = a3 ^ al ^ aes_pkg::xt(a3 ^ a0);
    end
    if (cmd.key_add)   st_nxt = st_r ^ rk_r;
    else if (cmd.last) st_nxt = sr ^ rk_nxt;
    else               st_nxt = mc ^ rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      nonce_r  <= '0;
      ctr_r    <= '0;
      round_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          8'(aes_pkg::REG_KEY_HIGH):      key_hi_r <= cfg_wdata;
          8'(aes_pkg::REG_KEY_LOW):       key_lo_r <= cfg_wdata;
          8'(aes_pkg::REG_NONCE):         nonce_r  <= cfg_wdata;
          8'(aes_pkg::REG_COUNTER_START): ctr_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.start) round_r <= '0;
      else if (cmd.advance) round_r <= round_r + 4'd1;
      if (cmd.last) ctr_r <= ctr_r + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      st_r  <= {nonce_r, ctr_r};
      txt_r <= {in_text_high, in_text_low};
      rk_r  <= {key_hi_r, key_lo_r};
      rc_r  <= 8'h01;
    end else if (cmd.advance) begin
      st_r <= st_nxt;
      if (!cmd.key_add) begin
        rk_r <= rk_nxt;
        rc_r <= aes_pkg::xt(rc_r);
      end
    end
    if (cmd.last) res_r <= txt_r ^ st_nxt;
  end

  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= 4'd11)
    else $error("round out of range");
  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |-> round_r == 4'd10)
    else $error("last at wrong round");
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last && !cfg_we |=> ctr_r == $past(ctr_r) + 64'd1)
    else $error("counter did not step");

endmodule

// ----- rtl/aes128_ctr_cipher.sv -----
// Channel  Ports                            Beat when
// input    in_valid/in_stall, in_text_*     in_valid && !in_stall
// output   out_valid/out_stall, out_result_* out_valid && !out_stall
// config   cfg_we, cfg_addr, cfg_wdata      cfg_we
// An item is taken while idle, then runs the key add and ten rounds in the shared
// round unit; its result is offered from the next cycle, when the next item may
// also be taken; no item is taken while a run is busy.
// Round keys are expanded on the fly, one round key per cycle while the run is not held.
// Reset (rst_n low, synchronous) clears key, nonce and counter to zero.
// A stalled result holds; the next item waits at its last round until the beat.
module aes128_ctr_cipher #(
  parameter int unsigned CFG_ADDR_W = aes_pkg::CfgAddrW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           in_text_high,
  input  logic [63:0]           in_text_low,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_result_high,
  output logic [63:0]           out_result_low
);

  aes_pkg::dp_cmd_t  cmd;
  aes_pkg::dp_stat_t stat;
  logic [aes_pkg::CfgAddrW-1:0] addr;

  assign addr = (CFG_ADDR_W > aes_pkg::CfgAddrW) &&
                (cfg_addr >= CFG_ADDR_W'(aes_pkg::NumRegs)) ?
                aes_pkg::CfgAddrW'(aes_pkg::NumRegs) :
                aes_pkg::CfgAddrW'(cfg_addr);

  aes_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  aes_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(addr),
    .cfg_wdata(cfg_wdata), .in_text_high(in_text_high), .in_text_low(in_text_low),
    .cmd(cmd), .stat(stat), .out_result_high(out_result_high),
    .out_result_low(out_result_low)
  );

endmodule
